@@ hdl/point_in_cylinder_classifier_assert.svh @@
// Assertion macros shared by the classifier RTL.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef POINT_IN_CYLINDER_CLASSIFIER_ASSERT_SVH
`define POINT_IN_CYLINDER_CLASSIFIER_ASSERT_SVH

// Same-cycle implication
`define PIC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pic_pkg.sv @@
package pic_pkg;

  // Coordinate format: signed fixed point, COORD_W bits
  localparam int COORD_W       = 16;
  localparam int RAD_W         = COORD_W - 1;
  localparam int FRAC_BITS_DEF = 8;

  // Register map
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_END_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TOL     = 3'd7;

  // Reset values of the nonzero registers
  localparam int END_Z_RST  = 256;
  localparam int RADIUS_RST = 256;
  localparam int TOL_RST    = 1;

  // Position classes
  localparam logic [1:0] CLS_INSIDE  = 2'd0;
  localparam logic [1:0] CLS_SURFACE = 2'd1;
  localparam logic [1:0] CLS_OUTSIDE = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] position_class;
    logic       contained;
    logic       degenerate_axis;
  } out_word_t;

endpackage

@@ hdl/pic_mul.sv @@
// Two-stage unsigned multiplier: four half-width partial products, then their sum.
module pic_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic             clk,
  input  logic             en_a,
  input  logic             en_b,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_r;
  logic [AL+BH-1:0] lh_r;
  logic [AH+BL-1:0] hl_r;
  logic [AH+BH-1:0] hh_r;
  logic [PW-1:0]    p_r;
  logic [PW-1:0]    p_nxt;

  // Partial products
  always_ff @(posedge clk) begin
    if (en_a) begin
      ll_r <= {{BL{1'b0}}, a[AL-1:0]}  * {{AL{1'b0}}, b[BL-1:0]};
      lh_r <= {{BH{1'b0}}, a[AL-1:0]}  * {{AL{1'b0}}, b[BW-1:BL]};
      hl_r <= {{BL{1'b0}}, a[AW-1:AL]} * {{AH{1'b0}}, b[BL-1:0]};
      hh_r <= {{BH{1'b0}}, a[AW-1:AL]} * {{AH{1'b0}}, b[BW-1:BL]};
    end
  end

  // Recombine: low a times high b sits at the b split, high a times low b at the a split
  always_comb begin
    p_nxt = (PW'(hh_r) << (AL + BL)) + (PW'(lh_r) << BL) + (PW'(hl_r) << AL) + PW'(ll_r);
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

@@ hdl/point_in_cylinder_classifier.sv @@
// Point-in-cylinder classifier, seven register stages.
// Path: an accepted word moves through stages 1 to 7 in turn; out_valid presents it from stage 7.
// Throughput: one word per cycle while out_ready holds; stages advance independently, so bubbles close up.
// Axis, length and limit terms are rebuilt from the registers through a_r, aa_r, q_r and the multipliers.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
`include "point_in_cylinder_classifier_assert.svh"

module point_in_cylinder_classifier import pic_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata
);

  localparam int DW   = COORD_W + 1;       // coordinate difference
  localparam int PW   = 2 * COORD_W + 1;   // signed a*v term
  localparam int SQW  = 2 * COORD_W;       // square of a difference
  localparam int QW   = 2 * COORD_W + 2;   // q and w
  localparam int SW   = 2 * COORD_W + 3;   // s
  localparam int R2W  = 2 * RAD_W;
  localparam int QR2W = QW + R2W;
  localparam int TQW  = RAD_W + QW;
  localparam int LW   = TQW + FRAC_BITS;
  localparam int EW   = 2 * QW + 1;
  localparam int CW   = (EW > LW + 1) ? EW : LW + 1;
  localparam int NSTG = 7;

  // Registers
  logic signed [COORD_W-1:0] start_r [3];
  logic signed [COORD_W-1:0] end_r [3];
  logic [RAD_W-1:0]          radius_r;
  logic [RAD_W-1:0]          tol_r;

  // Terms derived from the registers
  logic signed [DW-1:0]   a_r [3];
  logic signed [2*DW-1:0] aa_full [3];
  logic [SQW-1:0]         aa_r [3];
  logic [R2W-1:0]         r2_r;
  logic [R2W-1:0]         tt_r;
  logic [QW-1:0]          q_r;
  logic                   deg_r;
  logic [QR2W-1:0]        qr2;
  logic [TQW-1:0]         tq;
  logic [LW-1:0]          lim;

  // Pipeline control
  logic [NSTG:1] vld_r;
  logic [NSTG:1] vld_nxt;
  logic [NSTG:1] vld_src;
  logic [NSTG:1] rdy;

  // Stage payload
  logic signed [COORD_W-1:0] pt [3];
  logic signed [DW-1:0]      v_r [3];
  logic signed [2*DW-1:0]    av_full [3];
  logic signed [2*DW-1:0]    vv_full [3];
  logic signed [PW-1:0]      av_r [3];
  logic [SQW-1:0]            vv_r [3];
  logic signed [SW-1:0]      s_r;
  logic [QW-1:0]             w_r;
  logic                      s4_out_r;
  logic                      s4_cap_r;
  logic                      s5_out_r;
  logic                      s5_cap_r;
  logic                      s6_out_r;
  logic                      s6_cap_r;
  logic [2*QW-1:0]           qw;
  logic [2*QW-1:0]           ss;
  logic signed [EW-1:0]      e_r;
  logic signed [CW-1:0]      e_ext;
  logic signed [CW-1:0]      lim_ext;
  logic signed [CW-1:0]      nlim;
  logic                      near;
  logic [1:0]                cls;
  logic                      deg_flag;
  out_word_t                 out_word_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r[0] <= '0;
      start_r[1] <= '0;
      start_r[2] <= '0;
      end_r[0]   <= '0;
      end_r[1]   <= '0;
      end_r[2]   <= COORD_W'(END_Z_RST);
      radius_r   <= RAD_W'(RADIUS_RST);
      tol_r      <= RAD_W'(TOL_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X: start_r[0] <= cfg_wdata;
        REG_START_Y: start_r[1] <= cfg_wdata;
        REG_START_Z: start_r[2] <= cfg_wdata;
        REG_END_X:   end_r[0]   <= cfg_wdata;
        REG_END_Y:   end_r[1]   <= cfg_wdata;
        REG_END_Z:   end_r[2]   <= cfg_wdata;
        REG_RADIUS:  radius_r   <= cfg_wdata[RAD_W-1:0];
        REG_TOL:     tol_r      <= cfg_wdata[RAD_W-1:0];
      endcase
    end
  end

  // Axis vector and its squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aa_full[i] = a_r[i] * a_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_r[i]  <= DW'(end_r[i]) - DW'(start_r[i]);
      aa_r[i] <= aa_full[i][SQW-1:0];
    end
    r2_r  <= R2W'(radius_r) * R2W'(radius_r);
    tt_r  <= R2W'(tol_r) * R2W'(tol_r);
    q_r   <= QW'(aa_r[0]) + QW'(aa_r[1]) + QW'(aa_r[2]);
    deg_r <= (q_r == '0) || (q_r < QW'(tt_r));
  end

  // q*r^2 and tol*q
  pic_mul #(.AW(QW), .BW(R2W)) u_qr2 (
    .clk (clk), .en_a (1'b1), .en_b (1'b1), .a (q_r), .b (r2_r), .p (qr2)
  );

  pic_mul #(.AW(RAD_W), .BW(QW)) u_tq (
    .clk (clk), .en_a (1'b1), .en_b (1'b1), .a (tol_r), .b (q_r), .p (tq)
  );

  assign lim = LW'(tq) << FRAC_BITS;

  // Stage handshake: a stage loads when it is empty or its word moves on
  always_comb begin
    rdy[NSTG] = ~vld_r[NSTG] | out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
    vld_src = {vld_r[NSTG-1:1], in_valid};
    vld_nxt = (vld_src & rdy) | (vld_r & ~rdy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = rdy[1];

  // Stage 1: point relative to the first end point
  assign pt[0] = in_word.point_x;
  assign pt[1] = in_word.point_y;
  assign pt[2] = in_word.point_z;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        v_r[i] <= DW'(pt[i]) - DW'(start_r[i]);
      end
    end
  end

  // Stage 2: per-axis products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av_full[i] = a_r[i] * v_r[i];
      vv_full[i] = v_r[i] * v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int i = 0; i < 3; i++) begin
        av_r[i] <= av_full[i][PW-1:0];
        vv_r[i] <= vv_full[i][SQW-1:0];
      end
    end
  end

  // Stage 3: dot products s = a.v and w = v.v
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s_r <= SW'(av_r[0]) + SW'(av_r[1]) + SW'(av_r[2]);
      w_r <= QW'(vv_r[0]) + QW'(vv_r[1]) + QW'(vv_r[2]);
    end
  end

  // Stages 4 and 5: q*w and s*s; s matters only when 0 <= s <= q
  pic_mul #(.AW(QW), .BW(QW)) u_qw (
    .clk (clk), .en_a (rdy[4]), .en_b (rdy[5]), .a (q_r), .b (w_r), .p (qw)
  );

  pic_mul #(.AW(QW), .BW(QW)) u_ss (
    .clk (clk), .en_a (rdy[4]), .en_b (rdy[5]),
    .a (s_r[QW-1:0]), .b (s_r[QW-1:0]), .p (ss)
  );

  // Carry the span flags alongside the products
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_out_r <= s_r[SW-1] || (s_r[SW-2:0] > q_r);
      s4_cap_r <= (s_r == '0) || (s_r[SW-2:0] == q_r);
    end
    if (rdy[5]) begin
      s5_out_r <= s4_out_r;
      s5_cap_r <= s4_cap_r;
    end
  end

  // Stage 6: scaled radial excess E = q*w - s*s - q*r^2
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      e_r      <= EW'(qw) - EW'(ss) - EW'(qr2);
      s6_out_r <= s5_out_r;
      s6_cap_r <= s5_cap_r;
    end
  end

  // Stage 7: classify; |E| < lim tested as two compares against +/- lim
  always_comb begin
    e_ext   = CW'(e_r);
    lim_ext = CW'(lim);
    nlim    = -lim_ext;
    near    = (e_ext < lim_ext) && (e_ext > nlim);
    deg_flag = 1'b0;
    priority if (deg_r) begin
      cls      = CLS_OUTSIDE;
      deg_flag = 1'b1;
    end else if (s6_out_r) begin
      cls = CLS_OUTSIDE;
    end else if (near) begin
      cls = CLS_SURFACE;
    end else if (e_r[EW-1]) begin
      cls = s6_cap_r ? CLS_SURFACE : CLS_INSIDE;
    end else begin
      cls = CLS_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      out_word_r.position_class  <= cls;
      out_word_r.contained       <= (cls != CLS_OUTSIDE);
      out_word_r.degenerate_axis <= deg_flag;
    end
  end

  assign out_valid = vld_r[NSTG];
  assign out_word  = out_word_r;

  // Checks
  `PIC_ASSERT_IMPL(a_contained, out_valid, out_word.contained == (out_word.position_class != CLS_OUTSIDE), "contained disagrees with class")
  `PIC_ASSERT_IMPL(a_degen_out, out_valid && out_word.degenerate_axis, out_word.position_class == CLS_OUTSIDE, "degenerate axis not outside")
  `PIC_ASSERT_NEXT(a_last_move, vld_r[NSTG-1] && rdy[NSTG], out_valid, "word lost before output register")

endmodule

@@ dv/point_in_cylinder_classifier_checker.sv @@
module point_in_cylinder_classifier_checker import pic_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   inside_hits,
  output int                   surface_hits,
  output int                   outside_hits,
  output int                   degenerate_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the cylinder registers
  logic signed [COORD_W-1:0] axis_start [3];
  logic signed [COORD_W-1:0] axis_stop [3];
  logic [RAD_W-1:0]          radius_r;
  logic [RAD_W-1:0]          tol_r;

  // Predicted classes, oldest first
  out_word_t pending_classes [$];

  int mismatches = 0;
  int words_checked = 0;
  int n_inside = 0;
  int n_surface = 0;
  int n_outside = 0;
  int n_degenerate = 0;

  // Exact integer classification of one point against the shadow cylinder
  function automatic out_word_t classify_point(in_word_t p);
    longint axis_d [3];
    longint rel [3];
    longint len_sq;
    longint dist_sq;
    longint proj;
    longint tol_sq;
    logic signed [COORD_W-1:0] coord [3];
    logic signed [127:0] q_w, w_w, s_w, r_w, t_w;
    logic signed [127:0] excess, excess_mag, band;
    out_word_t res;
    coord[0] = p.point_x;
    coord[1] = p.point_y;
    coord[2] = p.point_z;
    len_sq = 0;
    dist_sq = 0;
    proj = 0;
    for (int i = 0; i < 3; i++) begin
      axis_d[i] = longint'(axis_stop[i]) - longint'(axis_start[i]);
      rel[i] = longint'(coord[i]) - longint'(axis_start[i]);
      len_sq += axis_d[i] * axis_d[i];
      dist_sq += rel[i] * rel[i];
      proj += axis_d[i] * rel[i];
    end
    tol_sq = longint'(tol_r) * longint'(tol_r);
    res.degenerate_axis = 1'b0;
    if (len_sq == 0 || len_sq < tol_sq) begin
      res.position_class = CLS_OUTSIDE;
      res.degenerate_axis = 1'b1;
    end else if (proj < 0 || proj > len_sq) begin
      res.position_class = CLS_OUTSIDE;
    end else begin
      // radial excess scaled by the squared axis length
      q_w = len_sq;
      w_w = dist_sq;
      s_w = proj;
      r_w = radius_r;
      t_w = tol_r;
      excess = q_w * w_w - s_w * s_w - q_w * r_w * r_w;
      excess_mag = (excess < 0) ? -excess : excess;
      band = (t_w * q_w) <<< FRAC_BITS_DEF;
      if (excess_mag < band) begin
        res.position_class = CLS_SURFACE;
      end else if (excess < 0) begin
        // points on an end cap count as surface
        res.position_class = (proj == 0 || proj == len_sq) ? CLS_SURFACE : CLS_INSIDE;
      end else begin
        res.position_class = CLS_OUTSIDE;
      end
    end
    res.contained = (res.position_class != CLS_OUTSIDE);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        axis_start[i] = '0;
        axis_stop[i] = '0;
      end
      axis_stop[2] = COORD_W'(END_Z_RST);
      radius_r = RAD_W'(RADIUS_RST);
      tol_r = RAD_W'(TOL_RST);
      pending_classes.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_START_X: axis_start[0] = cfg_wdata;
          REG_START_Y: axis_start[1] = cfg_wdata;
          REG_START_Z: axis_start[2] = cfg_wdata;
          REG_END_X:   axis_stop[0] = cfg_wdata;
          REG_END_Y:   axis_stop[1] = cfg_wdata;
          REG_END_Z:   axis_stop[2] = cfg_wdata;
          REG_RADIUS:  radius_r = cfg_wdata[RAD_W-1:0];
          REG_TOL:     tol_r = cfg_wdata[RAD_W-1:0];
          default: ;
        endcase
      end
      // Compare each result word against the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_classes.size() == 0) begin
          $error("result word with nothing predicted: class %0d contained %0d degenerate %0d",
                 out_word.position_class, out_word.contained, out_word.degenerate_axis);
          mismatches++;
        end else begin
          want = pending_classes.pop_front();
          words_checked++;
          if (out_word.position_class !== want.position_class) begin
            $error("position_class: expected %0d, got %0d",
                   want.position_class, out_word.position_class);
            mismatches++;
          end
          if (out_word.contained !== want.contained) begin
            $error("contained: expected %0d, got %0d", want.contained, out_word.contained);
            mismatches++;
          end
          if (out_word.degenerate_axis !== want.degenerate_axis) begin
            $error("degenerate_axis: expected %0d, got %0d",
                   want.degenerate_axis, out_word.degenerate_axis);
            mismatches++;
          end
          if (want.degenerate_axis) n_degenerate++;
          else if (want.position_class == CLS_INSIDE) n_inside++;
          else if (want.position_class == CLS_SURFACE) n_surface++;
          else n_outside++;
        end
      end
      // Predict every accepted point
      if (in_valid && in_ready) pending_classes.push_back(classify_point(in_word));
    end
    fail_count <= mismatches;
    pending <= pending_classes.size();
    checked <= words_checked;
    inside_hits <= n_inside;
    surface_hits <= n_surface;
    outside_hits <= n_outside;
    degenerate_hits <= n_degenerate;
  end

endmodule

@@ dv/point_in_cylinder_classifier_tb.sv @@
module point_in_cylinder_classifier_tb import pic_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES = 10;
  localparam int BATCHES = 12;
  localparam int BATCH_POINTS = 75;
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));
  localparam int RAD_MAX = (1 << RAD_W) - 1;

  typedef struct {
    int axis_a [3];
    int axis_b [3];
    int radius;
    int tol;
  } cylinder_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_START_X;
  logic [COORD_W-1:0]   cfg_wdata = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;
  int setups = 0;
  int points_sent = 0;
  int fail_count, pending, checked;
  int inside_hits, surface_hits, outside_hits, degenerate_hits;

  point_in_cylinder_classifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  point_in_cylinder_classifier_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_word         (in_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_word        (out_word),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked),
    .inside_hits     (inside_hits),
    .surface_hits    (surface_hits),
    .outside_hits    (outside_hits),
    .degenerate_hits (degenerate_hits)
  );

  always #5ns clk = ~clk;

  // Stall the result side at random and bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("point_in_cylinder_classifier: mismatch");
      $finish;
    end
  end

  function automatic in_word_t at_point(longint x, longint y, longint z);
    longint c [3];
    in_word_t p;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    for (int i = 0; i < 3; i++) begin
      if (c[i] > COORD_MAX) c[i] = COORD_MAX;
      if (c[i] < COORD_MIN) c[i] = COORD_MIN;
    end
    p.point_x = COORD_W'(c[0]);
    p.point_y = COORD_W'(c[1]);
    p.point_z = COORD_W'(c[2]);
    return p;
  endfunction

  function automatic cylinder_t make_cylinder(int ax, int ay, int az, int bx, int by, int bz,
                                              int r, int tol);
    cylinder_t c;
    c.axis_a = '{ax, ay, az};
    c.axis_b = '{bx, by, bz};
    c.radius = r;
    c.tol = tol;
    return c;
  endfunction

  // Present one word and hold it until accepted, then maybe idle
  task automatic push_point(in_word_t p);
    in_valid <= 1'b1;
    in_word <= p;
    do @(posedge clk); while (!in_ready);
    points_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, int data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= COORD_W'(data);
    @(posedge clk);
  endtask

  // Program a new cylinder once the pipeline is empty, then let it settle
  task automatic load_cylinder(cylinder_t c);
    wait_for_results();
    cfg_write(REG_START_X, c.axis_a[0]);
    cfg_write(REG_START_Y, c.axis_a[1]);
    cfg_write(REG_START_Z, c.axis_a[2]);
    cfg_write(REG_END_X, c.axis_b[0]);
    cfg_write(REG_END_Y, c.axis_b[1]);
    cfg_write(REG_END_Z, c.axis_b[2]);
    cfg_write(REG_RADIUS, c.radius);
    cfg_write(REG_TOL, c.tol);
    cfg_we <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    setups++;
  endtask

  task automatic set_idling(int send_pct, int stall);
    send_idle_pct = send_pct;
    stall_pct <= stall;
  endtask

  // Random cylinder, then points clustered around its wall and caps
  task automatic random_batch(int n_points, int hold_at);
    cylinder_t c;
    int along_k, r, t, du, dv, pick, other1, other2;
    longint rem, root, trial;
    longint axis_vec [3];
    longint coord [3];
    bit aligned, wild;
    aligned = ($urandom_range(3) != 0);
    along_k = $urandom_range(2);
    wild = ($urandom_range(5) == 0);
    for (int i = 0; i < 3; i++) begin
      c.axis_a[i] = int'($urandom_range(16000)) - 8000;
      c.axis_b[i] = aligned ? c.axis_a[i] : c.axis_a[i] + int'($urandom_range(12000)) - 6000;
    end
    if (aligned) begin
      c.axis_b[along_k] = c.axis_a[along_k] +
                          ($urandom_range(1) ? 1 : -1) * int'($urandom_range(12000, 64));
    end
    c.radius = $urandom_range(4000, 1);
    c.tol = $urandom_range(400);
    case ($urandom_range(7))
      0: c.radius = 1;
      1: c.radius = RAD_MAX;
      2: c.tol = 0;
      3: c.tol = RAD_MAX;
      default: ;
    endcase
    // Full-range register values now and then
    if (wild) begin
      aligned = 1'b0;
      for (int i = 0; i < 3; i++) begin
        c.axis_a[i] = int'($urandom_range(65535)) + COORD_MIN;
        c.axis_b[i] = int'($urandom_range(65535)) + COORD_MIN;
      end
      c.radius = $urandom_range(65535);
      c.tol = $urandom_range(65535);
    end
    load_cylinder(c);
    r = c.radius % (RAD_MAX + 1);
    for (int i = 0; i < 3; i++) axis_vec[i] = c.axis_b[i] - c.axis_a[i];

    for (int n = 0; n < n_points; n++) begin
      // Hold off until the pipeline has fully emptied
      if (n == hold_at) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
        for (int i = 0; i < 3; i++) coord[i] = int'($urandom_range(65535)) + COORD_MIN;
      end else begin
        // position along the axis, exactly on a cap now and then
        t = (pick < 20) ? ((pick < 15) ? 0 : 1000) : int'($urandom_range(1300)) - 150;
        for (int i = 0; i < 3; i++) coord[i] = c.axis_a[i] + axis_vec[i] * t / 1000;
        if (aligned) begin
          other1 = (along_k + 1) % 3;
          other2 = (along_k + 2) % 3;
          du = int'($urandom_range(2 * r)) - r;
          rem = longint'(r) * r - longint'(du) * du;
          root = 0;
          for (int b = 15; b >= 0; b--) begin
            trial = root + (longint'(1) << b);
            if (trial * trial <= rem) root = trial;
          end
          case ($urandom_range(2))
            0: dv = int'(root) + int'($urandom_range(4)) - 2;
            1: dv = int'(root * $urandom_range(100) / 100);
            default: dv = int'(root) + int'($urandom_range(r, 1));
          endcase
          if ($urandom_range(1)) dv = -dv;
          coord[other1] += du;
          coord[other2] += dv;
        end else begin
          for (int i = 0; i < 3; i++) coord[i] += int'($urandom_range(2 * r)) - r;
        end
      end
      push_point(at_point(coord[0], coord[1], coord[2]));
    end
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);
    set_idling(0, 0);

    // Reset cylinder: unit radius around z from 0 to 1
    push_point(at_point(0, 0, 128));
    push_point(at_point(256, 0, 128));
    push_point(at_point(0, 0, 0));
    push_point(at_point(0, 0, 256));
    push_point(at_point(0, 0, -1));
    push_point(at_point(0, 0, 257));
    push_point(at_point(300, 0, 128));
    push_point(at_point(COORD_MAX, COORD_MAX, COORD_MAX));
    push_point(at_point(COORD_MIN, COORD_MIN, COORD_MIN));

    // Coincident end points
    load_cylinder(make_cylinder(1000, -2000, 300, 1000, -2000, 300, 256, 1));
    push_point(at_point(1000, -2000, 300));
    push_point(at_point(COORD_MIN, COORD_MAX, 0));

    // Zero-length axis with zero tolerance
    load_cylinder(make_cylinder(0, 0, 0, 0, 0, 0, 256, 0));
    push_point(at_point(0, 0, 0));

    // Axis just shorter than the tolerance, then exactly equal
    load_cylinder(make_cylinder(0, 0, 0, 0, 0, 100, 64, 101));
    push_point(at_point(0, 0, 50));
    load_cylinder(make_cylinder(0, 0, 0, 0, 0, 100, 64, 100));
    push_point(at_point(0, 0, 50));

    // Full-span diagonal with largest radius and tolerance
    load_cylinder(make_cylinder(COORD_MIN, COORD_MIN, COORD_MIN,
                                COORD_MAX, COORD_MAX, COORD_MAX, RAD_MAX, RAD_MAX));
    push_point(at_point(COORD_MIN, COORD_MIN, COORD_MIN));
    push_point(at_point(COORD_MAX, COORD_MAX, COORD_MAX));
    push_point(at_point(0, 0, 0));
    push_point(at_point(COORD_MAX, COORD_MIN, 0));

    // Zero radius
    load_cylinder(make_cylinder(-512, 0, 0, 512, 0, 0, 0, 0));
    push_point(at_point(0, 0, 0));
    push_point(at_point(0, 1, 0));

    // Random cylinders, rotating through the idling patterns
    for (int k = 0; k < BATCHES; k++) begin
      case (k % 4)
        0: set_idling(0, 0);
        1: set_idling(65, 0);
        2: set_idling(0, 65);
        default: set_idling(21, 21);
      endcase
      random_batch(BATCH_POINTS, (k == 5) ? BATCH_POINTS / 2 : -1);
    end

    wait_for_results();
    $display("covered %0d points over %0d cylinder setups, %0d result words checked",
             points_sent, setups + 1, checked);
    $display("classes seen: inside %0d, surface %0d, outside %0d, degenerate axis %0d",
             inside_hits, surface_hits, outside_hits, degenerate_hits);
    if (fail_count == 0) begin
      $display("point_in_cylinder_classifier: match");
    end else begin
      $display("point_in_cylinder_classifier: mismatch");
    end
    $finish;
  end

endmodule
